// File: hw/rtl/ffpsd_pkg.sv
package ffpsd_pkg;

	localparam logic [7:0] ESC_BYTE   = 8'hFF;
	localparam logic [3:0] PREFIX_MAX = 4'd7;

	typedef enum logic [1:0] {
		PH_FIRST   = 2'd0,
		PH_PREFIX  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] size_value;
		logic [3:0]  code_bytes;
	} result_t;

	// Offset added to the payload of a code at level n: 2^(8n)-1.
	function automatic logic [63:0] level_offset(input logic [2:0] level);
		logic [63:0] off;
		case (level)
			3'd0:    off = 64'h0;
			3'd1:    off = 64'hFF;
			3'd2:    off = 64'hFFFF;
			3'd3:    off = 64'hFF_FFFF;
			3'd4:    off = 64'hFFFF_FFFF;
			3'd5:    off = 64'hFF_FFFF_FFFF;
			3'd6:    off = 64'hFFFF_FFFF_FFFF;
			3'd7:    off = 64'hFF_FFFF_FFFF_FFFF;
			default: off = 64'h0;
		endcase
		return off;
	endfunction

endpackage

// File: hw/rtl/ffpsd_if.sv
interface ffpsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

interface ffpsd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] size_value;
	logic [3:0]  code_bytes;

	modport source (output valid, output size_value, output code_bytes, input ready);
	modport sink   (input valid, input size_value, input code_bytes, output ready);
endinterface

// File: hw/rtl/ffpsd_decode.sv
module ffpsd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	output ffpsd_pkg::result_t res
);
	import ffpsd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  prefix_q, prefix_d;
	logic [3:0]  left_q, left_d;
	logic [63:0] acc_q, acc_d;
	logic [3:0]  seen_q, seen_d;

	logic [3:0]  level_next;
	logic [63:0] shifted;
	logic [3:0]  seen_inc;

	assign level_next = {1'b0, prefix_q} + 4'd1;
	assign shifted    = {acc_q[55:0], byte_in};
	assign seen_inc   = seen_q + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			prefix_q <= 3'd0;
			left_q   <= 4'd0;
			acc_q    <= 64'd0;
			seen_q   <= 4'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			prefix_q <= prefix_d;
			left_q   <= left_d;
			acc_q    <= acc_d;
			seen_q   <= seen_d;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		prefix_d       = prefix_q;
		left_d         = left_q;
		acc_d          = acc_q;
		seen_d         = seen_q;
		res.valid      = 1'b0;
		res.size_value = {56'd0, byte_in};
		res.code_bytes = 4'd1;
		case (phase_q)
			PH_PREFIX: begin
				seen_d   = seen_inc;
				prefix_d = level_next[2:0];
				// A non-escape byte, or the last allowed prefix byte, opens the payload.
				if (!(byte_in == ESC_BYTE && level_next < PREFIX_MAX)) begin
					acc_d   = {56'd0, byte_in};
					left_d  = level_next;
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (left_q <= 4'd1) begin
					res.valid      = 1'b1;
					res.size_value = shifted + level_offset(prefix_q);
					res.code_bytes = seen_inc;
					phase_d        = PH_FIRST;
					prefix_d       = 3'd0;
					left_d         = 4'd0;
					acc_d          = 64'd0;
					seen_d         = 4'd0;
				end else begin
					acc_d  = shifted;
					seen_d = seen_inc;
					left_d = left_q - 4'd1;
				end
			end
			default: begin
				if (byte_in != ESC_BYTE) begin
					res.valid = 1'b1;
					phase_d   = PH_FIRST;
				end else begin
					phase_d  = PH_PREFIX;
					prefix_d = 3'd0;
					left_d   = 4'd0;
					acc_d    = 64'd0;
					seen_d   = 4'd1;
				end
			end
		endcase
	end

endmodule

// File: hw/rtl/ff_prefix_size_decoder_top.sv
// A code's last byte passes the byte register and then the result register.
// Throughput: one byte per cycle unless sizes stalls a full result register;
// one result per completed code (1 to 15 bytes). The rate is set by the
// single-pass decode (state update, 64-bit offset add) between the registers.
// Reset (arst_n low, asynchronous) drops any partial code and empties both stages.
module ff_prefix_size_decoder_top (
	input  logic         clk,
	input  logic         arst_n,
	ffpsd_in_if.sink     stream,
	ffpsd_out_if.source  sizes
);
	import ffpsd_pkg::*;

	// Byte register: holds one accepted item until the decoder can take it.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register.
	logic        out_valid_q;
	logic [63:0] size_q;
	logic [3:0]  code_q;

	logic    advance;
	result_t res;

	// Advance the byte stage whenever the result register is empty or being taken.
	assign advance      = valid_s1 && (!out_valid_q || sizes.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.byte_in;
		end
	end

	// Decoder state only moves on an item that actually advances.
	ffpsd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (byte_s1),
		.res     (res)
	);

	// Load a result when one is produced; drop the valid flag once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (sizes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			size_q <= res.size_value;
			code_q <= res.code_bytes;
		end
	end

	assign sizes.valid      = out_valid_q;
	assign sizes.size_value = size_q;
	assign sizes.code_bytes = code_q;

endmodule

// File: hw/rtl/ffpsd_checker.sv
module ffpsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] size_value,
	input logic [3:0]  code_bytes
);
	import ffpsd_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(size_value) && $stable(code_bytes))
		else $error("stalled result changed or dropped");

	// Every code is 1 or 2n+1 bytes long, so the count is odd.
	a_code_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> code_bytes[0])
		else $error("even code length");

	// A one-byte code carries a value below the escape byte.
	a_short_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_bytes == 4'd1 |-> size_value[63:8] == 56'd0 &&
			size_value[7:0] != ESC_BYTE)
		else $error("one-byte code out of range");

	// A new result follows an item accepted at the input and held in the byte register.
	a_rise_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a feeding item");

endmodule

bind ff_prefix_size_decoder_top ffpsd_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (stream.valid),
	.in_ready   (stream.ready),
	.out_valid  (sizes.valid),
	.out_ready  (sizes.ready),
	.size_value (sizes.size_value),
	.code_bytes (sizes.code_bytes)
);

// File: test/tb_ff_prefix_size_decoder_top.sv
`timescale 1ns / 100ps

module tb_ff_prefix_size_decoder_top;
	import ffpsd_pkg::*;

	localparam int RANDOM_BYTES = 1000;
	localparam int CYCLE_LIMIT  = 400000;
	// A result follows its last byte via the byte and result registers; leave some margin on top.
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		logic [63:0] size_value;
		logic [3:0]  code_bytes;
	} size_item_t;

	// Receiver behavior, picked anew at random when the current mode runs out.
	typedef enum int {
		RX_OPEN,
		RX_BUSY_LIGHT,
		RX_BUSY_HEAVY,
		RX_LONG_STALL
	} rx_mode_t;

	// Decoder model plus the queue of sizes it still owes us.
	class size_scoreboard;
		phase_t      phase;
		logic [2:0]  level;
		logic [3:0]  payload_left;
		logic [63:0] acc;
		logic [3:0]  seen;
		size_item_t  pending_sizes[$];
		int          fail_count;
		int          checked;
		int          level_hits[8];

		function new();
			phase        = PH_FIRST;
			level        = 3'd0;
			payload_left = 4'd0;
			acc          = 64'd0;
			seen         = 4'd0;
			fail_count   = 0;
			checked      = 0;
			foreach (level_hits[i])
				level_hits[i] = 0;
		endfunction

		// Offset of level n is 2^(8n)-1.
		function logic [63:0] level_bias(logic [2:0] lvl);
			return (64'd1 << {lvl, 3'b000}) - 64'd1;
		endfunction

		function void note_byte(logic [7:0] b);
			logic [3:0] next_level;
			size_item_t item;
			next_level = {1'b0, level} + 4'd1;
			case (phase)
				PH_PREFIX: begin
					seen = seen + 4'd1;
					level = next_level[2:0];
					// The seventh byte after the leading escape always starts the payload.
					if (!(b == ESC_BYTE && next_level < PREFIX_MAX)) begin
						acc          = {56'd0, b};
						payload_left = next_level;
						phase        = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					acc  = {acc[55:0], b};
					seen = seen + 4'd1;
					if (payload_left <= 4'd1) begin
						// The add wraps modulo 2^64 on its own.
						item.size_value = acc + level_bias(level);
						item.code_bytes = seen;
						pending_sizes.push_back(item);
						level_hits[level]++;
						phase        = PH_FIRST;
						level        = 3'd0;
						payload_left = 4'd0;
						acc          = 64'd0;
						seen         = 4'd0;
					end else begin
						payload_left = payload_left - 4'd1;
					end
				end
				default: begin
					if (b != ESC_BYTE) begin
						item.size_value = {56'd0, b};
						item.code_bytes = 4'd1;
						pending_sizes.push_back(item);
						level_hits[0]++;
						phase = PH_FIRST;
					end else begin
						phase        = PH_PREFIX;
						level        = 3'd0;
						payload_left = 4'd0;
						acc          = 64'd0;
						seen         = 4'd1;
					end
				end
			endcase
		endfunction

		function void check_size(logic [63:0] v, logic [3:0] c);
			size_item_t item;
			checked++;
			if (pending_sizes.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("ERROR: unexpected size %h (%0d bytes)", v, c);
				return;
			end
			item = pending_sizes.pop_front();
			if (item.size_value !== v || item.code_bytes !== c) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("ERROR: size %0d expected %h (%0d bytes), got %h (%0d bytes)",
						checked, item.size_value, item.code_bytes, v, c);
			end
		endfunction

		function int pending();
			return pending_sizes.size();
		endfunction

		function void close_out();
			if (pending_sizes.size() != 0) begin
				$display("ERROR: %0d sizes never arrived", pending_sizes.size());
				fail_count += pending_sizes.size();
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ffpsd_in_if  stream_ch ();
	ffpsd_out_if size_ch ();

	ff_prefix_size_decoder_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.sizes  (size_ch)
	);

	size_scoreboard sb;
	int             cycle_count;
	int             bytes_accepted;
	int             burst_left;
	int             stall_left;
	int             mode_left;
	rx_mode_t       rx_mode;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Stop a hung run; the limit is many times the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d sizes outstanding",
				cycle_count, sb.pending());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: check each accepted size, then pick the next ready value.
	// The values read here are the ones held at the edge, before any update.
	always @(posedge clk) begin
		if (arst_n && size_ch.valid && size_ch.ready)
			sb.check_size(size_ch.size_value, size_ch.code_bytes);
		if (mode_left == 0) begin
			rx_mode   = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(30, 200);
		end else begin
			mode_left--;
		end
		case (rx_mode)
			RX_OPEN:       size_ch.ready <= 1'b1;
			RX_BUSY_LIGHT: size_ch.ready <= ($urandom_range(0, 3) != 0);
			RX_BUSY_HEAVY: size_ch.ready <= ($urandom_range(0, 3) == 0);
			default: begin
				// Hold ready low for a long stretch, then let one size through.
				if (stall_left > 0) begin
					stall_left--;
					size_ch.ready <= 1'b0;
				end else begin
					size_ch.ready <= 1'b1;
					stall_left = $urandom_range(5, 20);
				end
			end
		endcase
	end

	// Offer one byte and hold it until the handshake. At the end of a burst,
	// drop valid for a random gap first; valid changes at most once per edge.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				stream_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		stream_ch.valid   <= 1'b1;
		stream_ch.byte_in <= b;
		@(posedge clk);
		while (!stream_ch.ready)
			@(posedge clk);
		sb.note_byte(b);
		bytes_accepted++;
	endtask

	// Send one code of level lvl: lvl escape bytes, then the payload big-endian
	// (one byte at level 0, lvl+1 bytes below level 7, eight bytes at level 7).
	task automatic send_code(input int lvl, input logic [63:0] payload);
		int cnt;
		cnt = (lvl == 0) ? 1 : ((lvl == PREFIX_MAX) ? 8 : lvl + 1);
		repeat (lvl) send_byte(ESC_BYTE);
		for (int i = cnt - 1; i >= 0; i--)
			send_byte(payload[8*i +: 8]);
	endtask

	// Drop valid and hold off until every owed size has come out.
	task automatic wait_drained();
		stream_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          random_start;
		int          lvl;
		int          pick;
		bit          paused;
		logic [63:0] payload;

		sb                = new();
		cycle_count       = 0;
		bytes_accepted    = 0;
		burst_left        = 0;
		stall_left        = 0;
		mode_left         = 0;
		rx_mode           = RX_OPEN;
		paused            = 1'b0;
		arst_n            = 1'b0;
		stream_ch.valid   = 1'b0;
		stream_ch.byte_in = 8'h00;
		size_ch.ready     = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: short sizes at the field extremes and both bit patterns.
		send_code(0, 64'h00);
		send_code(0, 64'hFE);
		send_code(0, 64'h55);
		send_code(0, 64'hAA);
		// Each level with the smallest payload and the largest one that
		// does not extend the escape run (top byte 0xFE).
		for (int n = 1; n < PREFIX_MAX; n++) begin
			send_code(n, 64'd0);
			send_code(n, ((64'd1 << (8 * (n + 1))) - 64'd1) ^ (64'd1 << (8 * n)));
		end
		// Level 7: seven escapes end the run; an all-ones payload wraps the add.
		send_code(PREFIX_MAX, 64'd0);
		send_code(PREFIX_MAX, 64'hFFFF_FFFF_FFFF_FFFF);
		wait_drained();

		// Random: mostly well-formed codes, some loose bytes that break them.
		random_start = bytes_accepted;
		while (bytes_accepted - random_start < RANDOM_BYTES) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				repeat ($urandom_range(1, 3))
					send_byte($urandom_range(0, 1) ? ESC_BYTE : 8'($urandom_range(0, 255)));
			end else begin
				lvl     = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
				payload = {$urandom, $urandom};
				if ($urandom_range(0, 7) == 0)
					payload = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 1000);
				// Keep the leading payload byte off the escape value below level 7.
				if (lvl < PREFIX_MAX && payload[8*lvl +: 8] == ESC_BYTE)
					payload[8*lvl +: 8] = 8'($urandom_range(0, 254));
				send_code(lvl, payload);
			end
			if (!paused && bytes_accepted - random_start >= RANDOM_BYTES / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end

		wait_drained();
		sb.close_out();
		$display("Summary: %0d bytes sent, %0d sizes checked, %0d failures",
			bytes_accepted, sb.checked, sb.fail_count);
		$display("Summary: codes per level 0-7: %0d %0d %0d %0d %0d %0d %0d %0d",
			sb.level_hits[0], sb.level_hits[1], sb.level_hits[2], sb.level_hits[3],
			sb.level_hits[4], sb.level_hits[5], sb.level_hits[6], sb.level_hits[7]);
		if (sb.fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/ffpsd_pkg.sv
hw/rtl/ffpsd_if.sv
hw/rtl/ffpsd_decode.sv
hw/rtl/ff_prefix_size_decoder_top.sv
hw/rtl/ffpsd_checker.sv
test/tb_ff_prefix_size_decoder_top.sv
